FILE: rtl/color_match_centroid_core_macros.svh
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef COLOR_MATCH_CENTROID_CORE_MACROS_SVH
`define COLOR_MATCH_CENTROID_CORE_MACROS_SVH

// same-cycle implication
`define CMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cmc_pkg.sv
`default_nettype none
package cmc_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CH_W   = 8;
  localparam int SUM_W  = 34;
  localparam int CNT_W  = 23;
  localparam int POS_W  = 11;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int IDX_W  = 4;

  localparam logic [CH_W-1:0] TOL_RESET = 8'd20;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TARGET_BLUE  = 4'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_GREEN = 4'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_RED   = 4'd2;
  localparam logic [IDX_W-1:0] REG_TOLERANCE    = 4'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic [CNT_W-1:0] count;
  } cmc_frame_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } cmc_back_state_t;

  function automatic logic near_enough(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                       input logic [CH_W-1:0] tol);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d <= tol;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cmc_front.sv
`default_nettype none
module cmc_front import cmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CH_W-1:0]  cfg_data,
  input  wire logic             pix_accept,
  input  wire logic [CH_W-1:0]  pixel_blue,
  input  wire logic [CH_W-1:0]  pixel_green,
  input  wire logic [CH_W-1:0]  pixel_red,
  input  wire logic             end_of_row,
  input  wire logic             end_of_frame,
  output cmc_frame_t            frame,
  output logic                  frame_push
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  logic [CH_W-1:0]  tgt_b_r, tgt_g_r, tgt_r_r, tol_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] csum_r, csum_nxt, rsum_r, rsum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W:0]   csum_add, rsum_add;
  logic [CNT_W:0]   cnt_add;
  logic             match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_b_r <= '0;
      tgt_g_r <= '0;
      tgt_r_r <= '0;
      tol_r   <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_BLUE:  tgt_b_r <= cfg_data;
        REG_TARGET_GREEN: tgt_g_r <= cfg_data;
        REG_TARGET_RED:   tgt_r_r <= cfg_data;
        REG_TOLERANCE:    tol_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign match = near_enough(pixel_blue, tgt_b_r, tol_r) &&
                 near_enough(pixel_green, tgt_g_r, tol_r) &&
                 near_enough(pixel_red, tgt_r_r, tol_r);

  // saturating accumulate; carry out means the sum passed all ones
  assign csum_add = {1'b0, csum_r} + (SUM_W + 1)'(col_r);
  assign rsum_add = {1'b0, rsum_r} + (SUM_W + 1)'(row_r);
  assign cnt_add  = {1'b0, cnt_r} + (CNT_W + 1)'(1);

  always_comb begin
    csum_nxt = csum_r;
    rsum_nxt = rsum_r;
    cnt_nxt  = cnt_r;
    if (match) begin
      csum_nxt = csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
      rsum_nxt = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
      cnt_nxt  = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (end_of_row) begin
      col_nxt = '0;
      if (row_r < ROW_LAST) row_nxt = row_r + ROW_W'(1);
    end else if (col_r < COL_LAST) begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      csum_r <= '0;
      rsum_r <= '0;
      cnt_r  <= '0;
    end else if (pix_accept) begin
      if (end_of_frame) begin
        col_r  <= '0;
        row_r  <= '0;
        csum_r <= '0;
        rsum_r <= '0;
        cnt_r  <= '0;
      end else begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        csum_r <= csum_nxt;
        rsum_r <= rsum_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // the end-of-frame beat itself is counted before the frame is handed on
  assign frame_push    = pix_accept && end_of_frame;
  assign frame.col_sum = csum_nxt;
  assign frame.row_sum = rsum_nxt;
  assign frame.count   = cnt_nxt;

endmodule
`default_nettype wire

FILE: rtl/cmc_queue.sv
`default_nettype none
module cmc_queue import cmc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmc_frame_t push_data,
  input  wire logic pop,
  output cmc_frame_t pop_data,
  output logic      full,
  output logic      empty
);

  cmc_frame_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    fill_r;

  assign full     = (fill_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && !full)  wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop && !empty)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      case ({push && !full, pop && !empty})
        2'b10:   fill_r <= fill_r + (Q_AW + 1)'(1);
        2'b01:   fill_r <= fill_r - (Q_AW + 1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cmc_back.sv
`default_nettype none
module cmc_back import cmc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire cmc_frame_t        q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       out_centroid_column,
  output logic [POS_W-1:0]       out_centroid_row,
  output logic [CNT_W-1:0]       out_match_total,
  output logic                   out_found
);

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [SUM_W-1:0] quo;
  } div_t;

  // one restoring step: dividend bits shift out the top, quotient bits in at the bottom
  function automatic div_t div_step(input logic [CNT_W-1:0] rem, input logic [SUM_W-1:0] a,
                                    input logic [CNT_W-1:0] d);
    logic [CNT_W:0] sh;
    logic [CNT_W:0] diff;
    div_t           r;
    sh   = {rem, a[SUM_W-1]};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      r.rem = diff[CNT_W-1:0];
      r.quo = {a[SUM_W-2:0], 1'b1};
    end else begin
      r.rem = sh[CNT_W-1:0];
      r.quo = {a[SUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  cmc_back_state_t   state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  ca_r, ra_r;
  logic [CNT_W-1:0]  crem_r, rrem_r, div_r;
  div_t              cstep, rstep;
  logic              load, out_load;
  logic              out_valid_r;
  logic [POS_W-1:0]  ocol_r, orow_r, ocol_nxt, orow_nxt;
  logic [CNT_W-1:0]  otot_r;
  logic              ofound_r, found;

  assign cstep = div_step(crem_r, ca_r, div_r);
  assign rstep = div_step(rrem_r, ra_r, div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          load      = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == STEP_W'(SUM_W - 1)) state_nxt = BK_HOLD;
      end
      BK_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (load) begin
      ca_r   <= q_data.col_sum;
      ra_r   <= q_data.row_sum;
      div_r  <= q_data.count;
      crem_r <= '0;
      rrem_r <= '0;
      step_r <= '0;
    end else if (state_r == BK_DIV) begin
      ca_r   <= cstep.quo;
      ra_r   <= rstep.quo;
      crem_r <= cstep.rem;
      rrem_r <= rstep.rem;
      step_r <= step_r + STEP_W'(1);
    end
  end

  // quotient clamped to the field; no match gives a zero centroid
  assign found    = (div_r != '0);
  assign ocol_nxt = !found ? '0 : (|ca_r[SUM_W-1:POS_W]) ? '1 : ca_r[POS_W-1:0];
  assign orow_nxt = !found ? '0 : (|ra_r[SUM_W-1:POS_W]) ? '1 : ra_r[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
      otot_r   <= div_r;
      ofound_r <= found;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_centroid_column = ocol_r;
  assign out_centroid_row    = orow_r;
  assign out_match_total     = otot_r;
  assign out_found           = ofound_r;

endmodule
`default_nettype wire

FILE: rtl/color_match_centroid_core.sv
// Color-threshold blob centroid.
// in_* channel: one BGR pixel per beat, raster order, with end-of-row and
// end-of-frame marks; column and row positions are counted internally.
// A pixel is accepted every cycle while in_valid is high and the frame queue is not full.
// out_* channel: one beat per frame, carrying the truncated mean column and
// row of matching pixels, the match count and a found flag (centroid is zero
// when nothing matched).
// cfg_* channel: index 0..3 selects target blue, green, red and tolerance;
// it is always ready. Write only while no frame is in flight.
// Result path: the frame is popped from the frame queue, the divider runs 34
// steps, and the quotient goes into the output register once that register is
// free. The divider does one quotient bit per cycle for both axes.
// A two-entry frame queue sits between the accumulator and the divider, so
// in_ready drops only when two finished frames wait, i.e. frames shorter
// than the divider time or a receiver that holds out_ready low.
// Reset (rst_n low, synchronous) clears counters, sums, the queue and the
// output valid flag, and loads target 0/0/0 with tolerance 20.
`default_nettype none
module color_match_centroid_core import cmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CH_W-1:0]  in_pixel_blue,
  input  wire logic [CH_W-1:0]  in_pixel_green,
  input  wire logic [CH_W-1:0]  in_pixel_red,
  input  wire logic             in_end_of_row,
  input  wire logic             in_end_of_frame,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [POS_W-1:0]      out_centroid_column,
  output logic [POS_W-1:0]      out_centroid_row,
  output logic [CNT_W-1:0]      out_match_total,
  output logic                  out_found,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CH_W-1:0]  cfg_data
);

`include "color_match_centroid_core_macros.svh"

  cmc_frame_t push_frame, pop_frame;
  logic       frame_push, q_pop, q_full, q_empty, pix_accept;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !q_full;
  assign pix_accept = in_valid && in_ready;

  cmc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_accept  (pix_accept),
    .pixel_blue  (in_pixel_blue),
    .pixel_green (in_pixel_green),
    .pixel_red   (in_pixel_red),
    .end_of_row  (in_end_of_row),
    .end_of_frame(in_end_of_frame),
    .frame       (push_frame),
    .frame_push  (frame_push)
  );

  cmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (frame_push),
    .push_data(push_frame),
    .pop      (q_pop),
    .pop_data (pop_frame),
    .full     (q_full),
    .empty    (q_empty)
  );

  cmc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (pop_frame),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_centroid_column(out_centroid_column),
    .out_centroid_row   (out_centroid_row),
    .out_match_total    (out_match_total),
    .out_found          (out_found)
  );

  `CMC_ASSERT_NEXT(a_eof_queued, pix_accept && in_end_of_frame, !q_empty, "frame not queued")
  `CMC_ASSERT_IMPLY(a_found_count, out_valid && out_found, out_match_total != '0, "found w/o count")
  `CMC_ASSERT_IMPLY(a_none_zero, out_valid && !out_found, (out_centroid_column == '0) && (out_centroid_row == '0) && (out_match_total == '0), "empty frame not zero")

endmodule
`default_nettype wire

FILE: sim/color_match_centroid_checker.sv
`timescale 1ns / 100ps
module color_match_centroid_checker import cmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CH_W-1:0]  in_pixel_blue,
  input  logic [CH_W-1:0]  in_pixel_green,
  input  logic [CH_W-1:0]  in_pixel_red,
  input  logic             in_end_of_row,
  input  logic             in_end_of_frame,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [POS_W-1:0] out_centroid_column,
  input  logic [POS_W-1:0] out_centroid_row,
  input  logic [CNT_W-1:0] out_match_total,
  input  logic             out_found,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]  cfg_data,
  output int unsigned      errors,
  output int unsigned      pending
);

  localparam logic [SUM_W-1:0] SUM_TOP = '1;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [CNT_W-1:0] total;
    logic             found;
  } centroid_t;

  logic [CH_W-1:0]  tgt_blue, tgt_green, tgt_red, tol;
  int unsigned      col_pos, row_pos;
  logic [SUM_W-1:0] col_acc, row_acc;
  logic [CNT_W-1:0] hits;
  centroid_t        centroid_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic within_tol(logic [CH_W-1:0] px, logic [CH_W-1:0] tgt);
    int d;
    d = int'(px) - int'(tgt);
    if (d < 0) d = -d;
    return d <= int'(tol);
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc, int unsigned add);
    logic [SUM_W:0] ext;
    logic [SUM_W:0] s;
    ext = (SUM_W + 1)'(add);
    s = {1'b0, acc} + ext;
    return s[SUM_W] ? SUM_TOP : s[SUM_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] mean_pos(logic [SUM_W-1:0] acc, logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] q;
    q = acc / n;
    return (q > POS_TOP) ? POS_TOP : q[POS_W-1:0];
  endfunction

  task automatic clear_frame();
    col_pos = 0;
    row_pos = 0;
    col_acc = '0;
    row_acc = '0;
    hits    = '0;
  endtask

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic take_pixel();
    centroid_t c;
    if (within_tol(in_pixel_blue, tgt_blue) && within_tol(in_pixel_green, tgt_green) &&
        within_tol(in_pixel_red, tgt_red)) begin
      col_acc = sum_sat(col_acc, col_pos);
      row_acc = sum_sat(row_acc, row_pos);
      if (hits != CNT_TOP) hits = hits + 1'b1;
    end
    if (in_end_of_frame) begin
      c.found  = (hits != '0);
      c.total  = hits;
      c.column = c.found ? mean_pos(col_acc, hits) : '0;
      c.row    = c.found ? mean_pos(row_acc, hits) : '0;
      centroid_q.push_back(c);
      clear_frame();
    end else if (in_end_of_row) begin
      col_pos = 0;
      if (row_pos < MAX_HEIGHT - 1) row_pos++;
    end else if (col_pos < MAX_WIDTH - 1) begin
      col_pos++;
    end
  endtask

  task automatic check_centroid();
    centroid_t want;
    if (centroid_q.size() == 0) begin
      report($sformatf("unexpected result beat: column %0d row %0d total %0d found %0b",
                       out_centroid_column, out_centroid_row, out_match_total, out_found));
      return;
    end
    want = centroid_q.pop_front();
    check_field("centroid_column", 32'(out_centroid_column), 32'(want.column));
    check_field("centroid_row", 32'(out_centroid_row), 32'(want.row));
    check_field("match_total", 32'(out_match_total), 32'(want.total));
    check_field("found", 32'(out_found), 32'(want.found));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tgt_blue  = '0;
      tgt_green = '0;
      tgt_red   = '0;
      tol       = TOL_RESET;
      clear_frame();
      centroid_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_BLUE:  tgt_blue  = cfg_data;
          REG_TARGET_GREEN: tgt_green = cfg_data;
          REG_TARGET_RED:   tgt_red   = cfg_data;
          REG_TOLERANCE:    tol       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel();
      if (out_valid && out_ready) check_centroid();
    end
    pending <= centroid_q.size();
  end

endmodule

FILE: sim/tb_color_match_centroid_core.sv
`timescale 1ns / 100ps
module tb_color_match_centroid_core import cmc_pkg::*; ();

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 575;
  localparam int PHASES       = 5;

  typedef enum {
    PX_IN_BAND,
    PX_EDGE,
    PX_OUTSIDE,
    PX_ANY
  } px_kind_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CH_W-1:0]  in_pixel_blue;
  logic [CH_W-1:0]  in_pixel_green;
  logic [CH_W-1:0]  in_pixel_red;
  logic             in_end_of_row;
  logic             in_end_of_frame;
  logic             out_valid;
  logic             out_ready;
  logic [POS_W-1:0] out_centroid_column;
  logic [POS_W-1:0] out_centroid_row;
  logic [CNT_W-1:0] out_match_total;
  logic             out_found;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CH_W-1:0]  cfg_data;

  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      items_sent = 0;
  int unsigned      idle_cycles = 0;
  logic             tx_idle_en = 1'b1;
  logic             rx_idle_en = 1'b1;
  logic             hold_req = 1'b0;
  logic [CH_W-1:0]  cur_tgt [3];
  logic [CH_W-1:0]  cur_tol;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  color_match_centroid_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_blue       (in_pixel_blue),
    .in_pixel_green      (in_pixel_green),
    .in_pixel_red        (in_pixel_red),
    .in_end_of_row       (in_end_of_row),
    .in_end_of_frame     (in_end_of_frame),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_centroid_column (out_centroid_column),
    .out_centroid_row    (out_centroid_row),
    .out_match_total     (out_match_total),
    .out_found           (out_found),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  color_match_centroid_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_blue       (in_pixel_blue),
    .in_pixel_green      (in_pixel_green),
    .in_pixel_red        (in_pixel_red),
    .in_end_of_row       (in_end_of_row),
    .in_end_of_frame     (in_end_of_frame),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_centroid_column (out_centroid_column),
    .out_centroid_row    (out_centroid_row),
    .out_match_total     (out_match_total),
    .out_found           (out_found),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .errors              (mismatches),
    .pending             (outstanding)
  );

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] b, g, r, input logic eor, eof);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_blue   <= b;
    in_pixel_green  <= g;
    in_pixel_red    <= r;
    in_end_of_row   <= eor;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_target(input logic [CH_W-1:0] b, g, r, tl, input logic with_junk);
    logic [IDX_W-1:0] junk_idx;
    if (with_junk) begin
      // indexes past the tolerance register must be dropped
      junk_idx = IDX_W'($urandom_range(REG_TOLERANCE + 1, 2**IDX_W - 1));
      put_reg(junk_idx, CH_W'($urandom_range(0, 255)));
    end
    put_reg(REG_TARGET_BLUE, b);
    put_reg(REG_TARGET_GREEN, g);
    put_reg(REG_TARGET_RED, r);
    put_reg(REG_TOLERANCE, tl);
    cfg_valid <= 1'b0;
    cur_tgt[0] = b;
    cur_tgt[1] = g;
    cur_tgt[2] = r;
    cur_tol    = tl;
  endtask

  // stop sending, wait out all results and the divider tail
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] chan_value(logic [CH_W-1:0] tgt, px_kind_t kind);
    int lo, hi, v;
    lo = int'(tgt) - int'(cur_tol);
    hi = int'(tgt) + int'(cur_tol);
    case (kind)
      PX_IN_BAND: v = lo + int'($urandom_range(0, hi - lo));
      PX_EDGE:    v = $urandom_range(0, 1) ? hi : lo;
      PX_OUTSIDE: v = $urandom_range(0, 1) ? hi + 1 : lo - 1;
      default:    v = $urandom_range(0, 255);
    endcase
    if (kind == PX_OUTSIDE && (v < 0 || v > 255)) v = (v < 0) ? hi + 1 : lo - 1;
    if (kind == PX_OUTSIDE && (v < 0 || v > 255)) v = $urandom_range(0, 255);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  // rows of random length; the frame's last pixel may or may not close its row
  task automatic send_frame(int unsigned max_cols, int unsigned max_rows);
    int unsigned     rows, cols, pick, odd;
    logic [CH_W-1:0] ch [3];
    px_kind_t        kind;
    logic            last_row, last_px;
    rows = $urandom_range(1, max_rows);
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, max_cols);
      last_row = (r == rows - 1);
      for (int c = 0; c < cols; c++) begin
        last_px = (c == cols - 1);
        pick = $urandom_range(0, 9);
        odd  = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
          if (pick >= 8) kind = PX_ANY;
          else if (pick >= 6 && k == odd) kind = PX_OUTSIDE;
          else if (pick >= 4) kind = PX_EDGE;
          else kind = PX_IN_BAND;
          ch[k] = chan_value(cur_tgt[k], kind);
        end
        send_pixel(ch[0], ch[1], ch[2],
                   last_px && (!last_row || $urandom_range(0, 1) == 1),
                   last_px && last_row);
      end
    end
  endtask

  initial begin
    int unsigned goal;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_pixel_blue   <= '0;
    in_pixel_green  <= '0;
    in_pixel_red    <= '0;
    in_end_of_row   <= 1'b0;
    in_end_of_frame <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_TARGET_BLUE;
    cfg_data        <= '0;
    cur_tgt[0] = '0;
    cur_tgt[1] = '0;
    cur_tgt[2] = '0;
    cur_tol    = TOL_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: black target, tolerance edge on each channel
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd20, 8'd20, 8'd20, 1'b1, 1'b0);
    send_pixel(8'd21, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd21, 8'd20, 1'b0, 1'b0);
    send_pixel(8'd20, 8'd0, 8'd21, 1'b0, 1'b0);
    send_pixel(8'd7, 8'd13, 8'd20, 1'b1, 1'b1);
    // nothing matches, frame closes mid-row
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    drain();

    program_target(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd254, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    drain();

    program_target(8'd0, 8'd255, 8'd90, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      case (ph)
        0: program_target(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                          CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 40)), 1'b1);
        1: program_target(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        2: program_target(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                          CH_W'($urandom_range(0, 255)), 8'd255, 1'b1);
        3: program_target(8'd255, 8'd255, 8'd255, CH_W'($urandom_range(0, 60)), 1'b0);
        default: program_target(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                                CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                                1'b1);
      endcase
      goal = items_sent + RANDOM_ITEMS / PHASES;
      if (ph == 0) begin
        // tiny frames against a stalled receiver fill the frame queue
        hold_req = 1'b1;
        repeat (40) send_frame(2, 1);
      end
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) == 0) send_frame(40, 12);
        else send_frame(8, 5);
      end
    end
    drain();

    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
